>>> src/assert_macros.svh
// assertion macros shared by the allocator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge outside reset
`define BTA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that holds in the cycle after a trigger
`define BTA_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

>>> src/bta_pkg.sv
// types and constants shared by the block table allocator
package bta_pkg;

  localparam int IDX_W = 7;
  localparam int SZ_W  = 16;
  localparam int CW    = IDX_W + 1;

  typedef struct packed {
    logic [12:0] req_size;
    logic        fit_mode;
  } bta_req_t;

  typedef struct packed {
    logic        granted;
    logic [11:0] block_offset;
  } bta_rsp_t;

  typedef struct packed {
    logic [SZ_W-1:0] offset;
    logic [SZ_W-1:0] size;
    logic            used;
  } entry_t;

  typedef struct packed {
    logic             found;
    logic             done;
    logic [IDX_W-1:0] idx;
    logic [SZ_W-1:0]  size;
    logic [SZ_W-1:0]  offset;
  } cand_t;

  typedef struct packed {
    logic [SZ_W-1:0] want;
    logic            best;
    logic [CW-1:0]   count;
  } scan_t;

  typedef struct packed {
    logic             en;
    logic             split;
    logic [IDX_W-1:0] idx;
    logic [SZ_W-1:0]  want;
    logic [SZ_W-1:0]  new_off;
    logic [SZ_W-1:0]  rest;
  } upd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } state_t;

endpackage

>>> src/bta_cell.sv
// one table entry with its stage of the search chain
module bta_cell import bta_pkg::*; #(
  parameter int IDX        = 0,
  parameter bit HEAD       = 1'b0,
  parameter int HEAP_BYTES = 4096
) (
  input  logic   clk,
  input  logic   rst,
  input  scan_t  scan,
  input  cand_t  cand_in,
  output cand_t  cand_out,
  input  upd_t   upd,
  input  entry_t left,
  output entry_t ent
);

  localparam logic [CW-1:0] MY = CW'(IDX);

  logic          fits;
  logic          exact;
  logic [CW-1:0] pick;
  logic [CW-1:0] pick_nb;
  cand_t         cand_next;

  assign fits    = (MY < scan.count) && !ent.used && (ent.size >= scan.want);
  assign exact   = (ent.size == scan.want);
  assign pick    = {1'b0, upd.idx};
  assign pick_nb = pick + CW'(1);

  always_comb begin
    cand_next = cand_in;
    if (!cand_in.done && fits) begin
      if (!scan.best || exact || !cand_in.found || (ent.size <= cand_in.size)) begin
        cand_next.found  = 1'b1;
        cand_next.done   = !scan.best || exact;
        cand_next.idx    = MY[IDX_W-1:0];
        cand_next.size   = ent.size;
        cand_next.offset = ent.offset;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_out <= '0;
    end else begin
      cand_out <= cand_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      if (HEAD) begin
        ent.offset <= '0;
        ent.size   <= SZ_W'(HEAP_BYTES);
        ent.used   <= 1'b0;
      end
    end else if (upd.en) begin
      if (MY == pick) begin
        ent.used <= 1'b1;
        ent.size <= upd.want;
      end else if (upd.split && (MY == pick_nb)) begin
        ent.offset <= upd.new_off;
        ent.size   <= upd.rest;
        ent.used   <= 1'b0;
      end else if (upd.split && (MY > pick_nb)) begin
        ent <= left;
      end
    end
  end

endmodule

>>> src/block_table_allocator.sv
// top level of the block table allocator: control, counters and the cell chain
//
// channel | direction | handshake            | item
// req     | in        | req_valid, req_stall | bta_req_t  (req_size, fit_mode)
// rsp     | out       | rsp_valid, rsp_stall | bta_rsp_t  (granted, block_offset)
//
// a request is taken in idle; the scan state lets the candidate run down the chain, then the apply state
// loads the result into the output register and writes any grant into the table
// the search candidate moves one cell per cycle down the 2*MAX_BLOCKS-cell chain
// one request is in work at a time; the next is taken once the apply state has passed
// a stalled result holds the table update until the output register is free
// after reset entry 0 covers the whole heap as free and the block is ready at once
`include "assert_macros.svh"

module block_table_allocator import bta_pkg::*; #(
  parameter int HEAP_BYTES = 4096,
  parameter int MAX_BLOCKS = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  bta_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output bta_rsp_t rsp
);

  localparam int DEPTH = 2 * MAX_BLOCKS;
  localparam int CNT_W = $clog2(DEPTH);
  localparam int UB_W  = $clog2(MAX_BLOCKS + 1);

  state_t          state;
  state_t          state_next;
  logic [CNT_W-1:0] cnt;
  scan_t           scan;
  logic [UB_W-1:0] used_blocks;
  cand_t           cand [DEPTH];
  entry_t          ent [DEPTH];
  cand_t           fin;
  upd_t            upd;
  logic [SZ_W-1:0] rest;
  logic            req_take;
  logic            go;
  logic            limit;
  logic            full;
  logic            grant;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    bta_cell #(
      .IDX        (i),
      .HEAD       (i == 0),
      .HEAP_BYTES (HEAP_BYTES)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .scan     (scan),
      .cand_in  ((i == 0) ? cand_t'('0) : cand[(i == 0) ? 0 : i - 1]),
      .cand_out (cand[i]),
      .upd      (upd),
      .left     ((i == 0) ? entry_t'('0) : ent[(i == 0) ? 0 : i - 1]),
      .ent      (ent[i])
    );
  end

  assign fin      = cand[DEPTH-1];
  assign rest     = fin.size - scan.want;
  assign limit    = (used_blocks >= UB_W'(MAX_BLOCKS));
  assign full     = (scan.count >= CW'(DEPTH));
  assign grant    = !limit && fin.found && !((rest != '0) && full);
  assign go       = (state == ST_APPLY) && !(rsp_valid && rsp_stall);
  assign req_take = req_valid && !req_stall;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (cnt == CNT_W'(DEPTH - 1)) state_next = ST_APPLY;
      end
      ST_APPLY: begin
        if (go) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_stall   = (state != ST_IDLE);
    upd.en      = go && grant;
    upd.split   = (rest != '0);
    upd.idx     = fin.idx;
    upd.want    = scan.want;
    upd.new_off = fin.offset + scan.want;
    upd.rest    = rest;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cnt         <= '0;
      scan.count  <= CW'(1);
      used_blocks <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_SCAN) begin
        cnt <= cnt + CNT_W'(1);
      end else begin
        cnt <= '0;
      end
      if (req_take) begin
        scan.want <= SZ_W'(req.req_size);
        scan.best <= req.fit_mode;
      end
      if (upd.en) begin
        used_blocks <= used_blocks + UB_W'(1);
        if (upd.split) scan.count <= scan.count + CW'(1);
      end
      if (go) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rsp.granted      <= grant;
      rsp.block_offset <= grant ? fin.offset[11:0] : 12'd0;
    end
  end

  `BTA_ASSERT(a_used_limit, used_blocks <= UB_W'(MAX_BLOCKS), "used block count over limit")
  `BTA_ASSERT(a_count_limit, scan.count <= CW'(DEPTH), "entry count over table depth")
  `BTA_ASSERT(a_count_covers, scan.count >= CW'(used_blocks), "fewer entries than used blocks")
  `BTA_ASSERT_NEXT(a_grant_count, upd.en, used_blocks == $past(used_blocks) + UB_W'(1), "grant did not count")

endmodule

>>> verif/testbench.sv
// testbench for block_table_allocator: directed and random requests checked against a table model
module testbench import bta_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HEAP_BYTES  = 4096;
  localparam int MAX_BLOCKS  = 16;
  localparam int TABLE_DEPTH = 2 * MAX_BLOCKS;
  localparam int SIZE_MAX    = 8191;
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 200;

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_stall;
  bta_req_t req       = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  bta_rsp_t rsp;

  bit [12:0] slot_off   [TABLE_DEPTH];
  bit [12:0] slot_len   [TABLE_DEPTH];
  bit        slot_taken [TABLE_DEPTH];
  int        slot_count;
  int        blocks_out;

  bta_rsp_t pending_grants[$];
  int fails         = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_left     = 0;
  int hold_asks     = 0;
  int hold_taken    = 0;

  block_table_allocator #(
    .HEAP_BYTES(HEAP_BYTES),
    .MAX_BLOCKS(MAX_BLOCKS)
  ) dut (
    .clk,
    .rst,
    .req_valid,
    .req_stall,
    .req,
    .rsp_valid,
    .rsp_stall,
    .rsp
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bta_rsp_t allocate_block(bta_req_t item);
    bit [12:0] want;
    bit [12:0] pick_len;
    bit [12:0] rest;
    bit        best;
    bit        found;
    bit        stop;
    int        count;
    int        pick;
    bta_rsp_t  grant;
    want     = item.req_size;
    best     = item.fit_mode;
    count    = (slot_count > TABLE_DEPTH) ? TABLE_DEPTH : slot_count;
    found    = 1'b0;
    stop     = 1'b0;
    pick     = 0;
    pick_len = '0;
    grant    = '0;
    if (blocks_out >= MAX_BLOCKS) return grant;
    for (int i = 0; i < count; i++) begin
      if (!stop && !slot_taken[i] && slot_len[i] >= want) begin
        if (!best || slot_len[i] == want) begin
          pick  = i;
          found = 1'b1;
          stop  = 1'b1;
        end else if (!found || slot_len[i] <= pick_len) begin
          pick     = i;
          pick_len = slot_len[i];
          found    = 1'b1;
        end
      end
    end
    if (!found) return grant;
    rest = slot_len[pick] - want;
    if (rest != 0 && count >= TABLE_DEPTH) return grant;
    slot_taken[pick] = 1'b1;
    slot_len[pick]   = want;
    blocks_out++;
    if (rest != 0) begin
      for (int i = count; i > pick + 1; i--) begin
        slot_off[i]   = slot_off[i-1];
        slot_len[i]   = slot_len[i-1];
        slot_taken[i] = slot_taken[i-1];
      end
      slot_off[pick+1]   = slot_off[pick] + want;
      slot_len[pick+1]   = rest;
      slot_taken[pick+1] = 1'b0;
      slot_count         = count + 1;
    end
    grant.granted      = 1'b1;
    grant.block_offset = slot_off[pick][11:0];
    return grant;
  endfunction

  // -1 when no free block is left
  function automatic int largest_free();
    int top;
    top = -1;
    for (int i = 0; i < slot_count; i++) begin
      if (!slot_taken[i] && int'(slot_len[i]) > top) top = int'(slot_len[i]);
    end
    return top;
  endfunction

  task automatic send_request(input bit [12:0] size, input bit mode);
    bta_req_t item;
    item.req_size = size;
    item.fit_mode = mode;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pending_grants.push_back(allocate_block(item));
  endtask

  task automatic test_oversize();
    send_request(13'(SIZE_MAX), 1'b0);
    send_request(13'(SIZE_MAX), 1'b1);
    send_request(13'(HEAP_BYTES + 1), 1'b0);
    send_request(13'(HEAP_BYTES + 1), 1'b1);
  endtask

  task automatic test_zero_size();
    send_request(13'd0, 1'b0);
    send_request(13'd0, 1'b1);
  endtask

  task automatic test_fit_modes();
    send_request(13'd1, 1'b0);
    send_request(13'd1, 1'b1);
    send_request(13'd100, 1'b0);
    send_request(13'd255, 1'b1);
  endtask

  task automatic test_just_too_large();
    int free;
    free = largest_free();
    send_request(13'(free + 1), 1'b0);
    send_request(13'(free + 1), 1'b1);
  endtask

  // output held off while requests keep coming, so the input backs up
  task automatic test_output_held();
    int free;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_asks++;
    repeat (20) begin
      free = largest_free();
      send_request(13'($urandom_range(SIZE_MAX, free + 1)), 1'($urandom_range(1)));
    end
  endtask

  task automatic test_random(input int items, input int idle, input int stall);
    int        free;
    int        roll;
    bit [12:0] size;
    send_idle_pct = idle;
    stall_pct     = stall;
    repeat (items) begin
      free = largest_free();
      roll = $urandom_range(99);
      if (roll < 1 && free >= 0 && blocks_out < MAX_BLOCKS) begin
        // last grant takes the largest free block exactly
        if (blocks_out == MAX_BLOCKS - 1) size = 13'(free);
        else size = 13'($urandom_range(free < 300 ? free : 300));
      end else if (roll < 5) begin
        size = 13'($urandom_range(SIZE_MAX));
      end else begin
        size = 13'($urandom_range(SIZE_MAX, free + 1));
      end
      send_request(size, 1'($urandom_range(1)));
    end
  endtask

  always @(posedge clk) begin
    if (hold_taken != hold_asks) begin
      hold_taken <= hold_asks;
      hold_left  <= HOLD_CYCLES - 1;
      rsp_stall  <= 1'b1;
    end else if (hold_left != 0) begin
      rsp_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin : check_grants
    bta_rsp_t due;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_grants.size() == 0) begin
        $error("unexpected item: granted=%0d block_offset=%0d", rsp.granted, rsp.block_offset);
        fails++;
      end else begin
        due = pending_grants.pop_front();
        if (rsp.granted !== due.granted) begin
          $error("granted: expected %0d, got %0d", due.granted, rsp.granted);
          fails++;
        end
        if (rsp.block_offset !== due.block_offset) begin
          $error("block_offset: expected %0d, got %0d", due.block_offset, rsp.block_offset);
          fails++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
      else quiet++;
    end
    $display("FAIL block_table_allocator");
    $finish;
  end

  initial begin
    slot_off[0]   = '0;
    slot_len[0]   = 13'(HEAP_BYTES);
    slot_taken[0] = 1'b0;
    slot_count    = 1;
    blocks_out    = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_oversize();
    test_zero_size();
    test_fit_modes();
    test_just_too_large();
    test_output_held();
    test_random(335, 0, 0);
    test_random(335, 80, 0);
    test_random(335, 0, 80);
    test_random(335, 15, 15);

    req_valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (2 * MAX_BLOCKS + 4) @(posedge clk);
    if (fails == 0) begin
      $display("PASS block_table_allocator");
    end else begin
      $display("FAIL block_table_allocator");
    end
    $finish;
  end

endmodule
